// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot cache directory.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define LSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication from one cycle to the next, outside of reset.
`define LSC_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Types and constants shared by the slot cache directory modules.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int KEY_W       = 32;
    localparam int STAMP_W     = 32;
    localparam int IDX_W       = 6;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // At or above this signed stamp, only slot 0 can become the victim.
    localparam logic [STAMP_W-1:0] STAMP_LIMIT = 32'h7fff_ffff;
    // A removed slot is aged by this amount below the use counter.
    localparam logic [STAMP_W-1:0] REMOVE_AGE  = 32'd10;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // One directory entry as held in the slot memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Result handed from the controller to the output register.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] slot;
    } res_t;

endpackage

// ===== hw/rtl/lsc_slot_ram.sv =====
// ----------------------------------------------------------------------------
// lsc_slot_ram
// Single-port synchronous slot memory with registered read data.
// ----------------------------------------------------------------------------
module lsc_slot_ram #(
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                en,
    input  logic                we,
    input  logic [ADDR_W-1:0]   addr,
    input  lsc_pkg::entry_t     wdata,
    output lsc_pkg::entry_t     rdata
);
    import lsc_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // One access per cycle: a write, or a read that shows up next cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsc_ctrl
// Clears the slot memory after reset, then scans and updates it on requests.
// ----------------------------------------------------------------------------
module lsc_ctrl #(
    parameter int SLOTS = 64,
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lsc_pkg::op_t            in_op,
    input  logic [lsc_pkg::KEY_W-1:0] in_key,
    output logic                    res_valid,
    input  logic                    res_ready,
    output lsc_pkg::res_t           res,
    output logic                    mem_en,
    output logic                    mem_we,
    output logic [ADDR_W-1:0]       mem_addr,
    output lsc_pkg::entry_t         mem_wdata,
    input  lsc_pkg::entry_t         mem_rdata
);
    import lsc_pkg::*;

    localparam int EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [STAMP_W-1:0]        counter_reg, counter_next;
    op_t                       op_reg, op_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic signed [STAMP_W-1:0] oldest_reg, oldest_next;
    logic [ADDR_W-1:0]         victim_reg, victim_next;
    logic [ADDR_W-1:0]         slot_reg, slot_next;
    logic                      found_reg, found_next;

    logic                      last;
    logic                      match;
    logic                      older;
    logic [ADDR_W-1:0]         victim_c;
    logic [EXT_W-1:0]          slot_ext;

    // Compare the entry read in the previous cycle.
    assign last     = (idx_reg == LAST_IDX);
    assign match    = (mem_rdata.key == key_reg);
    assign older    = ($signed(mem_rdata.stamp) < oldest_reg);
    assign victim_c = older ? idx_reg : victim_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        counter_next = counter_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        oldest_next  = oldest_reg;
        victim_next  = victim_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        mem_en       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = idx_reg;
        mem_wdata    = '0;

        case (state_reg)
            // Zero one entry per cycle after reset.
            ST_CLEAR: begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                if (last) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // Take a request and issue the read of slot 0.
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_op;
                    key_next    = in_key;
                    oldest_next = $signed(STAMP_LIMIT);
                    victim_next = '0;
                    slot_next   = '0;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    mem_en      = 1'b1;
                    mem_addr    = '0;
                    if (in_op == OP_LOOKUP) begin
                        counter_next = counter_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            // Check one slot per cycle while reading the next one.
            ST_SCAN: begin
                if (match) begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                    state_next = ST_WRITE;
                end else begin
                    if (older) begin
                        oldest_next = $signed(mem_rdata.stamp);
                        victim_next = idx_reg;
                    end
                    if (last) begin
                        if (op_reg == OP_LOOKUP) begin
                            slot_next  = victim_c;
                            state_next = ST_WRITE;
                        end else begin
                            state_next = ST_HOLD;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        mem_en   = 1'b1;
                        mem_addr = idx_reg + 1'b1;
                    end
                end
            end
            // Write back the touched, installed or removed slot.
            ST_WRITE: begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = slot_reg;
                if (op_reg == OP_REMOVE) begin
                    mem_wdata.key   = '0;
                    mem_wdata.stamp = counter_reg - REMOVE_AGE;
                end else begin
                    mem_wdata.key   = key_reg;
                    mem_wdata.stamp = counter_reg;
                end
                state_next = ST_HOLD;
            end
            // Offer the result until the output register takes it.
            ST_HOLD: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    // The result carries the low bits of the slot number.
    assign slot_ext  = EXT_W'(slot_reg);
    assign res.found = found_reg;
    assign res.slot  = slot_ext[IDX_W-1:0];

    // Control state and use counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            counter_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            counter_reg <= counter_next;
        end
    end

    // Per-request working registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        oldest_reg <= oldest_next;
        victim_reg <= victim_next;
        slot_reg   <= slot_next;
        found_reg  <= found_next;
    end

endmodule

// ===== hw/rtl/lru_slot_cache_directory.sv =====
// A request scans the slots upward from slot 0; a hit ends the scan at its slot, and a
// remove that finds no match skips the write-back before the result is offered.
// A new item is taken only after the previous result has gone to the output register;
// the scan reads one slot per cycle from the single-port slot memory, then the write-back.
// After reset a clearing pass zeros every slot with s_tready held low;
// the use counter resets to zero.
// ----------------------------------------------------------------------------
// lru_slot_cache_directory
// Fully associative tile cache directory with timestamp LRU replacement.
// ----------------------------------------------------------------------------
module lru_slot_cache_directory #(
    parameter int SLOTS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lsc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] chunk_key
    input  logic                              s_tuser,   // [0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lsc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [5:0] slot_index, [7:6] zero
    output logic                              m_tuser    // [0] found
);
    import lsc_pkg::*;
    `include "assert_macros.svh"

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    entry_t            mem_wdata;
    entry_t            mem_rdata;

    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg;

    lsc_slot_ram #(
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    lsc_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_key    (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Output register: frees the controller as soon as a result is taken.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_res_reg.slot);
    assign m_tuser  = m_res_reg.found;

    // Only one request is in flight at a time.
    `LSC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a request is in flight")
    // The slot memory is never written while a request may be taken.
    `LSC_ASSERT(a_no_write_when_idle, aclk, aresetn, !(mem_we && s_tready), "slot memory written while idle")
    // A result waiting on the output register stays offered unchanged.
    `LSC_ASSERT_NEXT(a_result_held, aclk, aresetn, res_valid && !res_ready, res_valid && $stable(res), "pending result dropped or changed")

endmodule

// ===== tb/lru_slot_cache_directory_checker.sv =====
// ----------------------------------------------------------------------------
// lru_slot_cache_directory_checker
// Watches both stream channels of the slot cache directory. It keeps its own
// copy of the slot keys, stamps and use counter, and predicts found and slot
// for every accepted request. It then compares each accepted result with the
// oldest prediction.
// ----------------------------------------------------------------------------
module lru_slot_cache_directory_checker #(
    parameter int SLOTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lsc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] chunk_key
    input  logic                            s_tuser,   // [0] op
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lsc_pkg::OUT_TDATA_W-1:0] m_tdata,   // [5:0] slot_index, [7:6] zero
    input  logic                            m_tuser,   // [0] found
    output int                              mismatches,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    logic [KEY_W-1:0]   tile_keys   [SLOTS];
    logic [STAMP_W-1:0] tile_stamps [SLOTS];
    logic [STAMP_W-1:0] use_count;
    res_t               pending_results [$];

    // Applies one request to the shadow directory and returns its result.
    function automatic res_t apply_request(input op_t op, input logic [KEY_W-1:0] key);
        res_t               res;
        logic [STAMP_W-1:0] oldest;
        int                 victim;
        bit                 matched;
        res     = '0;
        oldest  = STAMP_LIMIT;
        victim  = 0;
        matched = 1'b0;
        if (op == OP_LOOKUP) begin
            use_count = use_count + 1'b1;
            // Scan upward; the first match wins, otherwise track the oldest stamp.
            for (int i = 0; i < SLOTS && !matched; i++) begin
                if (tile_keys[i] == key) begin
                    tile_stamps[i] = use_count;
                    matched        = 1'b1;
                    res.found      = 1'b1;
                    res.slot       = IDX_W'(i);
                end else if ($signed(tile_stamps[i]) < $signed(oldest)) begin
                    oldest = tile_stamps[i];
                    victim = i;
                end
            end
            if (!matched) begin
                tile_keys[victim]   = key;
                tile_stamps[victim] = use_count;
                res.slot            = IDX_W'(victim);
            end
        end else begin
            // A remove empties the first matching slot and ages its stamp.
            for (int i = 0; i < SLOTS && !matched; i++) begin
                if (tile_keys[i] == key) begin
                    tile_stamps[i] = use_count - REMOVE_AGE;
                    tile_keys[i]   = '0;
                    matched        = 1'b1;
                    res.found      = 1'b1;
                    res.slot       = IDX_W'(i);
                end
            end
        end
        return res;
    endfunction

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("ERROR %0t ns: %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatches++;
    endtask

    // Compares one result transfer with the oldest prediction.
    task automatic check_result();
        res_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result transfer with no request pending", '0, m_tdata);
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser !== want.found) begin
            report_mismatch("found flag", want.found, m_tuser);
        end
        if (m_tdata[IDX_W-1:0] !== want.slot) begin
            report_mismatch("slot index", want.slot, m_tdata[IDX_W-1:0]);
        end
        if (m_tdata[OUT_TDATA_W-1:IDX_W] !== '0) begin
            report_mismatch("tdata padding bits", '0, m_tdata[OUT_TDATA_W-1:IDX_W]);
        end
    endtask

    // Both channels are sampled at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                tile_keys[i]   = '0;
                tile_stamps[i] = '0;
            end
            use_count = '0;
            pending_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(apply_request(op_t'(s_tuser), s_tdata));
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

// ===== tb/lru_slot_cache_directory_tb.sv =====
// ----------------------------------------------------------------------------
// lru_slot_cache_directory_tb
// Drives lookups and removes into the slot cache directory: a directed opening
// on extreme keys, empty slots and aged removes, then random traffic over a
// small key set so that hits, misses and evictions all occur. Four phases vary
// sender gaps and receiver stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module lru_slot_cache_directory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    localparam int SLOTS           = 64;
    localparam int POOL_KEYS       = 96;
    localparam int HOT_KEYS        = 24;
    localparam int ITEMS_PER_PHASE = 462;
    localparam int PHASES          = 4;
    localparam int DRAIN_CYCLES    = SLOTS + 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    logic [KEY_W-1:0] key_pool [POOL_KEYS];
    int phase_idle  [PHASES] = '{0, 81, 0, 33};
    int phase_stall [PHASES] = '{0, 0, 81, 33};

    // Clock with a 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    lru_slot_cache_directory #(
        .SLOTS(SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lru_slot_cache_directory_checker #(
        .SLOTS(SLOTS)
    ) dir_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // The receiver stalls at random, redrawn at every falling edge.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if neither channel moves a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request after a random gap and returns at the falling edge
    // after its transfer.
    task automatic send_request(input op_t op, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = key;
        s_tuser  = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Holds the sender off until every predicted result has been seen.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int               roll;
        int               pick;
        op_t              op;
        logic [KEY_W-1:0] key;

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening: empty-slot key zero, extreme keys, aged removes.
        send_request(OP_LOOKUP, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h7fff_ffff);
        send_request(OP_LOOKUP, 32'h8000_0000);
        send_request(OP_LOOKUP, 32'hffff_ffff);
        send_request(OP_LOOKUP, 32'h0000_0001);
        send_request(OP_LOOKUP, 32'h5555_5555);
        send_request(OP_LOOKUP, 32'haaaa_aaaa);
        send_request(OP_LOOKUP, 32'h8000_0000);
        // A remove while the counter is below ten leaves a negative stamp.
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_LOOKUP, 32'h1234_5678);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_REMOVE, 32'hffff_ffff);
        send_request(OP_LOOKUP, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'hffff_ffff);
        send_request(OP_REMOVE, 32'h7fff_ffff);
        send_request(OP_LOOKUP, 32'h7fff_ffff);
        send_request(OP_REMOVE, 32'h0bad_cafe);
        wait_drained();

        // Key set larger than the directory, so that slots get evicted.
        for (int i = 0; i < POOL_KEYS; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'hffff_ffff;

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            repeat (ITEMS_PER_PHASE) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    // Noise: any key, any operation.
                    key = $urandom;
                    op  = op_t'($urandom_range(1));
                end else begin
                    // Mostly a hot subset of keys so that hits are common.
                    pick = $urandom_range(1) ? $urandom_range(HOT_KEYS - 1)
                                             : $urandom_range(POOL_KEYS - 1);
                    key  = key_pool[pick];
                    op   = (roll < 20) ? OP_REMOVE : OP_LOOKUP;
                end
                send_request(op, key);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (outstanding != 0) begin
            $display("ERROR: %0d predicted results never arrived", outstanding);
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_slot_ram.sv
hw/rtl/lsc_ctrl.sv
hw/rtl/lru_slot_cache_directory.sv
tb/lru_slot_cache_directory_checker.sv
tb/lru_slot_cache_directory_tb.sv
